// ----- hdl/spf_pkg.sv -----
// ----------------------------------------------------------------------------
// spf_pkg
// Shared types and constants for the sensor packet framer.
// ----------------------------------------------------------------------------
package spf_pkg;

  localparam int unsigned MAX_PAYLOAD = 256;
  localparam int unsigned PLEN_W      = 9;   // payload length and length field
  localparam int unsigned SUM_W       = 16;  // checksum width
  localparam int unsigned ADDR_W      = 32;
  localparam int unsigned HDR_W       = 16;
  localparam int unsigned BYTE_W      = 8;
  localparam int unsigned CFG_IDX_W   = 8;
  localparam int unsigned CFG_DATA_W  = 32;

  localparam logic [HDR_W-1:0]  HEADER_RESET  = 16'hEF01;
  localparam logic [ADDR_W-1:0] ADDRESS_RESET = 32'hFFFF_FFFF;

  // Configuration register indexes
  localparam logic [CFG_IDX_W-1:0] REG_HEADER_WORD     = 8'd0;
  localparam logic [CFG_IDX_W-1:0] REG_DEFAULT_ADDRESS = 8'd1;

  // Queue between front and back
  localparam int unsigned QUEUE_DEPTH = 4;
  localparam int unsigned QPTR_W      = $clog2(QUEUE_DEPTH);

  // One classified item, ready to be serialized
  typedef struct packed {
    logic              is_start;   // emit header, address, id, length first
    logic              has_data;   // emit the payload byte
    logic              has_cksum;  // close the packet with the checksum
    logic [HDR_W-1:0]  header;
    logic [ADDR_W-1:0] addr;
    logic [BYTE_W-1:0] pid;
    logic [PLEN_W-1:0] len;
    logic [BYTE_W-1:0] data;
    logic [SUM_W-1:0]  cksum;
  } spf_desc_t;

endpackage

// ----- hdl/spf_front.sv -----
// ----------------------------------------------------------------------------
// spf_front
// Holds the configuration registers, tracks packet state and turns each
// accepted item into a descriptor for the serializer.
// ----------------------------------------------------------------------------
module spf_front (
  input  logic                             clk_i,
  input  logic                             rst_ni,
  input  logic                             cfg_valid_i,
  input  logic [spf_pkg::CFG_IDX_W-1:0]    cfg_index_i,
  input  logic [spf_pkg::CFG_DATA_W-1:0]   cfg_data_i,
  input  logic                             accept_i,
  input  logic [spf_pkg::BYTE_W-1:0]       packet_id_i,
  input  logic [spf_pkg::PLEN_W-1:0]       payload_length_i,
  input  logic [spf_pkg::ADDR_W-1:0]       address_i,
  input  logic [spf_pkg::BYTE_W-1:0]       data_byte_i,
  output spf_pkg::spf_desc_t               desc_o
);

  logic [spf_pkg::HDR_W-1:0]  header_q;
  logic [spf_pkg::ADDR_W-1:0] def_addr_q;
  logic                       in_packet_q, in_packet_d;
  logic [spf_pkg::PLEN_W-1:0] bytes_left_q, bytes_left_d;
  logic [spf_pkg::SUM_W-1:0]  sum_q, sum_d;

  logic [spf_pkg::PLEN_W-1:0] plen_sat;
  logic [spf_pkg::PLEN_W-1:0] len;
  logic [spf_pkg::PLEN_W-1:0] bl_next;
  logic [spf_pkg::SUM_W-1:0]  sum_start;
  logic [spf_pkg::SUM_W-1:0]  sum_mid;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      header_q   <= spf_pkg::HEADER_RESET;
      def_addr_q <= spf_pkg::ADDRESS_RESET;
    end else if (cfg_valid_i) begin
      if (cfg_index_i == spf_pkg::REG_HEADER_WORD) begin
        header_q <= cfg_data_i[spf_pkg::HDR_W-1:0];
      end else if (cfg_index_i == spf_pkg::REG_DEFAULT_ADDRESS) begin
        def_addr_q <= cfg_data_i[spf_pkg::ADDR_W-1:0];
      end
    end
  end

  always_comb begin
    // saturate oversized lengths
    if (payload_length_i > spf_pkg::PLEN_W'(spf_pkg::MAX_PAYLOAD)) begin
      plen_sat = spf_pkg::PLEN_W'(spf_pkg::MAX_PAYLOAD);
    end else begin
      plen_sat = payload_length_i;
    end
    len       = plen_sat + spf_pkg::PLEN_W'(2);
    sum_start = {8'd0, packet_id_i} + {7'd0, len}
              + ((plen_sat != '0) ? {8'd0, data_byte_i} : 16'd0);
    sum_mid   = sum_q + {8'd0, data_byte_i};
    bl_next   = (bytes_left_q != '0) ? bytes_left_q - spf_pkg::PLEN_W'(1) : '0;

    desc_o.header = header_q;
    desc_o.addr   = (address_i == '0) ? def_addr_q : address_i;
    desc_o.pid    = packet_id_i;
    desc_o.len    = len;
    desc_o.data   = data_byte_i;

    if (!in_packet_q) begin
      desc_o.is_start  = 1'b1;
      desc_o.has_data  = (plen_sat != '0);
      desc_o.has_cksum = (plen_sat <= spf_pkg::PLEN_W'(1));
      desc_o.cksum     = sum_start;
      in_packet_d      = (plen_sat > spf_pkg::PLEN_W'(1));
      bytes_left_d     = in_packet_d ? plen_sat - spf_pkg::PLEN_W'(1) : '0;
      sum_d            = in_packet_d ? sum_start : '0;
    end else begin
      desc_o.is_start  = 1'b0;
      desc_o.has_data  = 1'b1;
      desc_o.has_cksum = (bl_next == '0);
      desc_o.cksum     = sum_mid;
      in_packet_d      = (bl_next != '0);
      bytes_left_d     = bl_next;
      sum_d            = in_packet_d ? sum_mid : '0;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      in_packet_q  <= 1'b0;
      bytes_left_q <= '0;
      sum_q        <= '0;
    end else if (accept_i) begin
      in_packet_q  <= in_packet_d;
      bytes_left_q <= bytes_left_d;
      sum_q        <= sum_d;
    end
  end

endmodule

// ----- hdl/spf_queue.sv -----
// ----------------------------------------------------------------------------
// spf_queue
// Small register FIFO of descriptors between the front and the serializer.
// ----------------------------------------------------------------------------
module spf_queue (
  input  logic                clk_i,
  input  logic                rst_ni,
  input  logic                push_i,
  input  spf_pkg::spf_desc_t  push_data_i,
  output logic                full_o,
  input  logic                pop_i,
  output logic                empty_o,
  output spf_pkg::spf_desc_t  head_o
);

  spf_pkg::spf_desc_t             mem_q [spf_pkg::QUEUE_DEPTH];
  logic [spf_pkg::QPTR_W-1:0]     wptr_q, rptr_q;
  logic [spf_pkg::QPTR_W:0]       count_q, count_d;

  assign full_o  = (count_q == (spf_pkg::QPTR_W+1)'(spf_pkg::QUEUE_DEPTH));
  assign empty_o = (count_q == '0);
  assign head_o  = mem_q[rptr_q];

  always_ff @(posedge clk_i) begin
    if (push_i) begin
      mem_q[wptr_q] <= push_data_i;
    end
  end

  always_comb begin
    count_d = count_q;
    if (push_i && !pop_i) begin
      count_d = count_q + (spf_pkg::QPTR_W+1)'(1);
    end else if (pop_i && !push_i) begin
      count_d = count_q - (spf_pkg::QPTR_W+1)'(1);
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wptr_q  <= '0;
      rptr_q  <= '0;
      count_q <= '0;
    end else begin
      if (push_i) begin
        wptr_q <= wptr_q + spf_pkg::QPTR_W'(1);
      end
      if (pop_i) begin
        rptr_q <= rptr_q + spf_pkg::QPTR_W'(1);
      end
      count_q <= count_d;
    end
  end

endmodule

// ----- hdl/spf_back.sv -----
// ----------------------------------------------------------------------------
// spf_back
// Serializes the descriptor at the queue head into frame bytes, one per
// cycle while out_stall_i is low, into the output register.
// ----------------------------------------------------------------------------
module spf_back (
  input  logic                        clk_i,
  input  logic                        rst_ni,
  input  logic                        empty_i,
  input  spf_pkg::spf_desc_t          head_i,
  output logic                        pop_o,
  output logic                        out_valid_o,
  input  logic                        out_stall_i,
  output logic [spf_pkg::BYTE_W-1:0]  frame_byte_o,
  output logic                        end_of_run_o,
  output logic                        end_of_frame_o
);

  localparam logic [3:0] SLOT_HDR_HI = 4'd0;
  localparam logic [3:0] SLOT_HDR_LO = 4'd1;
  localparam logic [3:0] SLOT_A3     = 4'd2;
  localparam logic [3:0] SLOT_A2     = 4'd3;
  localparam logic [3:0] SLOT_A1     = 4'd4;
  localparam logic [3:0] SLOT_A0     = 4'd5;
  localparam logic [3:0] SLOT_PID    = 4'd6;
  localparam logic [3:0] SLOT_LEN_HI = 4'd7;
  localparam logic [3:0] SLOT_LEN_LO = 4'd8;
  localparam logic [3:0] SLOT_DATA   = 4'd9;
  localparam logic [3:0] SLOT_CK_HI  = 4'd10;
  localparam logic [3:0] SLOT_CK_LO  = 4'd11;

  logic       first_q;
  logic [3:0] slot_q;
  logic [3:0] slot;
  logic [3:0] slot_next;
  logic       last;
  logic       load;

  logic                       out_valid_q;
  logic [spf_pkg::BYTE_W-1:0] byte_q, byte_d;
  logic                       eor_q, eof_q;

  assign load = !empty_i && (!out_valid_q || !out_stall_i);
  assign pop_o = load && last;

  always_comb begin
    slot      = first_q ? (head_i.is_start ? SLOT_HDR_HI : SLOT_DATA) : slot_q;
    slot_next = slot + 4'd1;
    last      = 1'b0;
    case (slot)
      SLOT_LEN_LO: begin
        if (head_i.has_data) begin
          slot_next = SLOT_DATA;
        end else begin
          slot_next = SLOT_CK_HI;
        end
      end
      SLOT_DATA:  last = !head_i.has_cksum;
      SLOT_CK_LO: last = 1'b1;
      default:    last = 1'b0;
    endcase

    case (slot)
      SLOT_HDR_HI: byte_d = head_i.header[15:8];
      SLOT_HDR_LO: byte_d = head_i.header[7:0];
      SLOT_A3:     byte_d = head_i.addr[31:24];
      SLOT_A2:     byte_d = head_i.addr[23:16];
      SLOT_A1:     byte_d = head_i.addr[15:8];
      SLOT_A0:     byte_d = head_i.addr[7:0];
      SLOT_PID:    byte_d = head_i.pid;
      SLOT_LEN_HI: byte_d = {7'd0, head_i.len[8]};
      SLOT_LEN_LO: byte_d = head_i.len[7:0];
      SLOT_DATA:   byte_d = head_i.data;
      SLOT_CK_HI:  byte_d = head_i.cksum[15:8];
      SLOT_CK_LO:  byte_d = head_i.cksum[7:0];
      default:     byte_d = '0;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      first_q     <= 1'b1;
      slot_q      <= SLOT_HDR_HI;
      out_valid_q <= 1'b0;
    end else begin
      if (load) begin
        first_q     <= last;
        slot_q      <= slot_next;
        out_valid_q <= 1'b1;
      end else if (!out_stall_i) begin
        // drop the taken byte when nothing follows
        out_valid_q <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (load) begin
      byte_q <= byte_d;
      eor_q  <= last;
      eof_q  <= (slot == SLOT_CK_LO);
    end
  end

  assign out_valid_o    = out_valid_q;
  assign frame_byte_o   = byte_q;
  assign end_of_run_o   = eor_q;
  assign end_of_frame_o = eof_q;

endmodule

// ----- hdl/sensor_packet_framer.sv -----
// ----------------------------------------------------------------------------
// sensor_packet_framer
// Frames sensor command packets byte by byte.
// ----------------------------------------------------------------------------
// Usage: the input channel (in_valid_i / in_stall_o) takes one item per
// transaction. The first item of a packet produces header, address, id and
// length bytes, then the first payload byte if any; later items produce their
// payload byte. The last byte of a packet is followed by the 16-bit checksum.
// The output channel (out_valid_o / out_stall_i) moves one frame byte per
// transaction; end_of_run_o marks the last byte of an item and
// end_of_frame_o the low checksum byte.
// An accepted item is registered in the queue, and its bytes in the output
// register. One output byte per cycle leaves the single serializer while
// out_stall_i is low; an item is 10 to 12 bytes at packet start, else 1 or 3.
// A four-entry descriptor queue lets payload items keep entering while a
// packet start is still being sent; in_stall_o rises only when it is full.
// Reset clears packet state and the queue and reloads the header (0xEF01) and
// default address (0xFFFFFFFF). When out_stall_i is high the current byte is
// held and the queue fills. Config writes (cfg_valid_i) always complete.
// ----------------------------------------------------------------------------
module sensor_packet_framer (
  input  logic                            clk_i,
  input  logic                            rst_ni,
  input  logic                            cfg_valid_i,
  output logic                            cfg_ready_o,
  input  logic [spf_pkg::CFG_IDX_W-1:0]   cfg_index_i,
  input  logic [spf_pkg::CFG_DATA_W-1:0]  cfg_data_i,
  input  logic                            in_valid_i,
  output logic                            in_stall_o,
  input  logic [spf_pkg::BYTE_W-1:0]      packet_id_i,
  input  logic [spf_pkg::PLEN_W-1:0]      payload_length_i,
  input  logic [spf_pkg::ADDR_W-1:0]      address_i,
  input  logic [spf_pkg::BYTE_W-1:0]      data_byte_i,
  output logic                            out_valid_o,
  input  logic                            out_stall_i,
  output logic [spf_pkg::BYTE_W-1:0]      frame_byte_o,
  output logic                            end_of_run_o,
  output logic                            end_of_frame_o
);

  logic               accept;
  logic               full;
  logic               empty;
  logic               pop;
  spf_pkg::spf_desc_t desc;
  spf_pkg::spf_desc_t head;

  assign cfg_ready_o = 1'b1;
  assign in_stall_o  = full;
  assign accept      = in_valid_i && !full;

  spf_front u_front (
    .clk_i            (clk_i),
    .rst_ni           (rst_ni),
    .cfg_valid_i      (cfg_valid_i),
    .cfg_index_i      (cfg_index_i),
    .cfg_data_i       (cfg_data_i),
    .accept_i         (accept),
    .packet_id_i      (packet_id_i),
    .payload_length_i (payload_length_i),
    .address_i        (address_i),
    .data_byte_i      (data_byte_i),
    .desc_o           (desc)
  );

  spf_queue u_queue (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .push_i      (accept),
    .push_data_i (desc),
    .full_o      (full),
    .pop_i       (pop),
    .empty_o     (empty),
    .head_o      (head)
  );

  spf_back u_back (
    .clk_i          (clk_i),
    .rst_ni         (rst_ni),
    .empty_i        (empty),
    .head_i         (head),
    .pop_o          (pop),
    .out_valid_o    (out_valid_o),
    .out_stall_i    (out_stall_i),
    .frame_byte_o   (frame_byte_o),
    .end_of_run_o   (end_of_run_o),
    .end_of_frame_o (end_of_frame_o)
  );

endmodule
